### src/ptq_pkg.sv
// Shared types and codes for the priority task queue with delay list.
package ptq_pkg;

    localparam int ENT_W = 32;   // packed entry: data_handle, event_code, task_id
    localparam int CNT_W = 16;   // delay countdown width
    localparam int DROP_W = 5;   // expired drop counter width

    typedef enum logic [1:0] {
        REQ_SUBMIT = 2'd0,
        REQ_TIMED  = 2'd1,
        REQ_PROC   = 2'd2,
        REQ_TICK   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUBMIT,
        S_FIND,
        S_POP,
        S_POPWAIT,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_cmd;

endpackage

### src/ptq_fifo_bank.sv
// Ring FIFOs, one per priority level, sharing one storage memory.
module ptq_fifo_bank #(
    parameter int NUM_LEVELS = 4,
    parameter int DEPTH = 16,
    parameter int LW = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ptq_pkg::t_fifo_cmd          i_cmd,
    input  logic [LW-1:0]               i_push_lvl,
    input  logic [LW-1:0]               i_pop_lvl,
    input  logic [ptq_pkg::ENT_W-1:0]   i_push_word,
    output logic [NUM_LEVELS-1:0]       o_nonempty,
    output logic [NUM_LEVELS-1:0]       o_full,
    output logic [ptq_pkg::ENT_W-1:0]   o_rd_data
);
    import ptq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int AW = $clog2(NUM_LEVELS * DEPTH);

    logic [ENT_W-1:0] r_mem [NUM_LEVELS*DEPTH];
    logic [PW-1:0]    r_wptr [NUM_LEVELS];
    logic [PW-1:0]    r_rptr [NUM_LEVELS];
    logic [PW:0]      r_fill [NUM_LEVELS];
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;

    assign w_waddr = AW'(AW'(i_push_lvl) * AW'(DEPTH) + AW'(r_wptr[i_push_lvl]));
    assign w_raddr = AW'(AW'(i_pop_lvl) * AW'(DEPTH) + AW'(r_rptr[i_pop_lvl]));

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            o_nonempty[l] = (r_fill[l] != '0);
            o_full[l]     = (r_fill[l] == (PW+1)'(DEPTH));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_waddr] <= i_push_word;
        end
        if (i_cmd.pop) begin
            o_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_wptr[l] <= '0;
                r_rptr[l] <= '0;
                r_fill[l] <= '0;
            end
        end else begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (i_cmd.push && i_push_lvl == LW'(l)) begin
                    r_wptr[l] <= (r_wptr[l] == PW'(DEPTH-1)) ? '0 : r_wptr[l] + 1'b1;
                end
                if (i_cmd.pop && i_pop_lvl == LW'(l)) begin
                    r_rptr[l] <= (r_rptr[l] == PW'(DEPTH-1)) ? '0 : r_rptr[l] + 1'b1;
                end
                if ((i_cmd.push && i_push_lvl == LW'(l)) && !(i_cmd.pop && i_pop_lvl == LW'(l))) begin
                    r_fill[l] <= r_fill[l] + 1'b1;
                end else if (!(i_cmd.push && i_push_lvl == LW'(l)) &&
                             (i_cmd.pop && i_pop_lvl == LW'(l))) begin
                    r_fill[l] <= r_fill[l] - 1'b1;
                end
            end
        end
    end

endmodule

### src/priority_task_queue_with_delay_list_top.sv
// Top level: multi-level priority FIFO scheduler with a delay list.
//
// Input channel (i_in_valid / o_in_stall) carries one request beat: submit,
// timed submit, process or tick. Output channel (o_out_valid / i_out_stall)
// returns exactly one result beat per request, in request order.
// Each request is worked by a small sequencer over shared storage:
//   submit       : one FIFO push, then the result goes to the output register.
//   timed submit : one delay slot checked per cycle until a free one is found.
//   process      : one FIFO read if a level is non-empty, then the delay memory
//                  is swept one entry per cycle through its read port.
//   tick         : same sweep with read-modify-write.
// The delay sweep sets the rate for process and tick requests.
// o_in_stall is high while a request is being worked; one new request is
// taken while a finished result still waits in the output register.
// If the receiver stalls, the result beat holds; a second finished result
// waits in the sequencer until the output register frees.
// Reset (synchronous, active low) empties all FIFOs, clears every delay slot
// and sets expire level to 1. There is no clearing pass.
// i_cfg_we writes expire level; write it only when the block is idle.
module priority_task_queue_with_delay_list_top #(
    parameter int NUM_LEVELS = 4,
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_priority_req,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_event_code,
    input  logic [15:0] i_data_handle,
    input  logic [15:0] i_delay,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic        o_dispatch_valid,
    output logic [7:0]  o_out_task_id,
    output logic [7:0]  o_out_event_code,
    output logic [15:0] o_out_data_handle,
    output logic [4:0]  o_dropped_expired
);
    import ptq_pkg::*;

    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int PW = $clog2(DEPTH);
    localparam int IW = PW + 1;

    // sequencer and latched request
    t_state r_state, n_state;
    t_req             r_req;
    logic [1:0]       r_lvl;
    logic [ENT_W-1:0] r_word;
    logic [CNT_W-1:0] r_dly;
    logic [1:0]       r_exp;

    // sweep index and pipeline stage behind the delay memory read
    logic [IW-1:0] r_idx;
    logic          r_pv;
    logic [PW-1:0] r_pidx;

    // delay list: valid flops plus one memory of {count, entry}
    logic [DEPTH-1:0]         r_dvalid;
    logic [CNT_W+ENT_W-1:0]   r_dmem [DEPTH];
    logic [CNT_W+ENT_W-1:0]   r_drd;

    // result being built
    logic              r_res_acc, r_res_dv;
    logic [ENT_W-1:0]  r_res_word;
    logic [DROP_W-1:0] r_res_drop;

    // output register
    logic [ENT_W-1:0] r_out_word;

    // FIFO bank control
    t_fifo_cmd        w_cmd;
    logic [LW-1:0]    w_push_lvl;
    logic [LW-1:0]    w_pop_lvl;
    logic [ENT_W-1:0] w_push_word;
    logic [NUM_LEVELS-1:0] w_nonempty, w_full;
    logic [ENT_W-1:0] w_rd_data;

    logic w_accept, w_out_free, w_any;
    logic w_sub_ok, w_exp_ok, w_exp_full;
    logic w_idx_end, w_slot_free, w_hit_exp, w_hit_tick;
    logic [LW-1:0] w_first;
    logic [CNT_W-1:0] w_pcnt;
    logic [ENT_W-1:0] w_pent;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_idx_end   = (r_idx == IW'(DEPTH));
    assign w_slot_free = !r_dvalid[r_idx[PW-1:0]];
    assign w_sub_ok    = (32'(r_lvl) < NUM_LEVELS) && !w_full[LW'(r_lvl)];
    assign w_exp_ok    = (32'(r_exp) < NUM_LEVELS);
    assign w_exp_full  = w_full[LW'(r_exp)];
    assign {w_pcnt, w_pent} = r_drd;
    assign w_hit_exp  = r_pv && (r_req == REQ_PROC) && r_dvalid[r_pidx] && (w_pcnt == '0);
    assign w_hit_tick = r_pv && (r_req == REQ_TICK) && r_dvalid[r_pidx] && (w_pcnt != '0);

    // lowest-numbered non-empty level
    always_comb begin
        w_any   = 1'b0;
        w_first = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (w_nonempty[l]) begin
                w_any   = 1'b1;
                w_first = LW'(l);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_SUBMIT: n_state = S_SUBMIT;
                        REQ_TIMED:  n_state = S_FIND;
                        REQ_PROC:   n_state = S_POP;
                        REQ_TICK:   n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SUBMIT:  n_state = S_DONE;
            S_FIND:    if (w_idx_end || w_slot_free) n_state = S_DONE;
            S_POP:     n_state = w_any ? S_POPWAIT : S_SCAN;
            S_POPWAIT: n_state = S_SCAN;
            S_SCAN:    if (w_idx_end && !r_pv) n_state = S_DONE;
            S_DONE:    if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // FIFO bank control
    always_comb begin
        w_cmd       = '0;
        w_push_lvl  = LW'(r_lvl);
        w_pop_lvl   = w_first;
        w_push_word = r_word;
        unique case (r_state)
            S_SUBMIT: w_cmd.push = w_sub_ok;
            S_POP:    w_cmd.pop  = w_any;
            S_SCAN: begin
                w_push_lvl  = LW'(r_exp);
                w_push_word = w_pent;
                w_cmd.push  = w_hit_exp && w_exp_ok && !w_exp_full;
            end
            default: w_cmd = '0;
        endcase
    end

    ptq_fifo_bank #(
        .NUM_LEVELS (NUM_LEVELS),
        .DEPTH      (DEPTH),
        .LW         (LW)
    ) u_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_push_lvl  (w_push_lvl),
        .i_pop_lvl   (w_pop_lvl),
        .i_push_word (w_push_word),
        .o_nonempty  (w_nonempty),
        .o_full      (w_full),
        .o_rd_data   (w_rd_data)
    );

    // delay memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIND && !w_idx_end && w_slot_free) begin
            r_dmem[r_idx[PW-1:0]] <= {r_dly, r_word};
        end else if (r_state == S_SCAN && w_hit_tick) begin
            r_dmem[r_pidx] <= {w_pcnt - 1'b1, w_pent};
        end
        if (r_state == S_SCAN && !w_idx_end) begin
            r_drd <= r_dmem[r_idx[PW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= t_req'(i_req_type);
            r_lvl  <= i_priority_req;
            r_word <= {i_data_handle, i_event_code, i_task_id};
            r_dly  <= i_delay;
        end
        if (r_state == S_POPWAIT) begin
            r_res_word <= w_rd_data;
        end else if (w_accept) begin
            r_res_word <= '0;
        end
        if (r_state == S_SCAN) begin
            r_pidx <= r_idx[PW-1:0];
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_word        <= r_res_word;
            o_accepted        <= r_res_acc;
            o_dispatch_valid  <= r_res_dv;
            o_dropped_expired <= r_res_drop;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exp       <= 2'd1;
            r_idx       <= '0;
            r_pv        <= 1'b0;
            r_dvalid    <= '0;
            r_res_acc   <= 1'b0;
            r_res_dv    <= 1'b0;
            r_res_drop  <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_exp <= i_cfg_data;
            end
            // r_pv is cleared by the default arm below
            if (w_accept) begin
                r_idx      <= '0;
                r_res_acc  <= 1'b0;
                r_res_dv   <= 1'b0;
                r_res_drop <= '0;
            end
            unique case (r_state)
                S_SUBMIT: r_res_acc <= w_sub_ok;
                S_FIND: begin
                    if (!w_idx_end) begin
                        if (w_slot_free) begin
                            r_dvalid[r_idx[PW-1:0]] <= 1'b1;
                            r_res_acc <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_POP: r_res_dv <= w_any;
                S_SCAN: begin
                    r_pv <= !w_idx_end;
                    if (!w_idx_end) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (w_hit_exp) begin
                        r_dvalid[r_pidx] <= 1'b0;
                        if ((!w_exp_ok || w_exp_full) && r_res_drop != '1) begin
                            r_res_drop <= r_res_drop + 1'b1;
                        end
                    end
                end
                default: r_pv <= 1'b0;
            endcase
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_task_id     = r_out_word[7:0];
    assign o_out_event_code  = r_out_word[15:8];
    assign o_out_data_handle = r_out_word[31:16];

endmodule

### src/ptq_checker.sv
// Port-level checks for the priority task queue top level, with bind.
module ptq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_accepted,
    input logic        o_dispatch_valid,
    input logic [7:0]  o_out_task_id,
    input logic [7:0]  o_out_event_code,
    input logic [15:0] o_out_data_handle,
    input logic [4:0]  o_dropped_expired
);

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while idle did not make the block busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid && $stable(o_accepted))
        else $error("stalled result beat changed");

    a_no_dispatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_dispatch_valid) |->
        (o_out_task_id == 8'd0 && o_out_event_code == 8'd0 && o_out_data_handle == 16'd0))
        else $error("dispatch fields not zero without dispatch");

    a_accept_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (!o_dispatch_valid && o_dropped_expired == 5'd0))
        else $error("accepted beat also shows process results");

endmodule

bind priority_task_queue_with_delay_list_top ptq_checker u_ptq_checker (.*);

### sim/priority_task_queue_with_delay_list_top_tb.sv
// Self-checking testbench for the priority task queue with delay list.
`timescale 1ns / 1ps

module priority_task_queue_with_delay_list_top_tb;
    import ptq_pkg::*;

    localparam int LEVELS = 4;
    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // one result beat as seen on the output ports
    typedef struct packed {
        logic        accepted;
        logic        dispatch_valid;
        logic [7:0]  task_id;
        logic [7:0]  event_code;
        logic [15:0] data_handle;
        logic [4:0]  dropped;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [1:0]  i_priority_req;
    logic [7:0]  i_task_id;
    logic [7:0]  i_event_code;
    logic [15:0] i_data_handle;
    logic [15:0] i_delay;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    logic        o_dispatch_valid;
    logic [7:0]  o_out_task_id;
    logic [7:0]  o_out_event_code;
    logic [15:0] o_out_data_handle;
    logic [4:0]  o_dropped_expired;

    priority_task_queue_with_delay_list_top #(
        .NUM_LEVELS(LEVELS),
        .DEPTH(SLOTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_priority_req(i_priority_req),
        .i_task_id(i_task_id),
        .i_event_code(i_event_code),
        .i_data_handle(i_data_handle),
        .i_delay(i_delay),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_accepted(o_accepted),
        .o_dispatch_valid(o_dispatch_valid),
        .o_out_task_id(o_out_task_id),
        .o_out_event_code(o_out_event_code),
        .o_out_data_handle(o_out_data_handle),
        .o_dropped_expired(o_dropped_expired)
    );

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- shadow of the scheduler state ----
    logic [31:0] lvl_store [LEVELS][SLOTS];
    int unsigned lvl_wr [LEVELS];
    int unsigned lvl_rd [LEVELS];
    int unsigned lvl_fill [LEVELS];
    logic [31:0] timer_entry [SLOTS];
    logic [15:0] timer_count [SLOTS];
    logic        timer_busy [SLOTS];
    logic [1:0]  shadow_expire_level;

    t_outcome pending_outcomes [$];
    int       fail_count;
    int       idle_cycles;
    int       long_hold;     // cycles of forced receiver hold-off left
    logic     tb_done;

    function automatic bit level_push(int unsigned lvl, logic [31:0] word);
        if (lvl >= LEVELS || lvl_fill[lvl] >= SLOTS) return 1'b0;
        lvl_store[lvl][lvl_wr[lvl]] = word;
        lvl_wr[lvl] = (lvl_wr[lvl] + 1) % SLOTS;
        lvl_fill[lvl]++;
        return 1'b1;
    endfunction

    function automatic void shadow_reset();
        for (int l = 0; l < LEVELS; l++) begin
            lvl_wr[l] = 0;
            lvl_rd[l] = 0;
            lvl_fill[l] = 0;
        end
        for (int s = 0; s < SLOTS; s++) begin
            timer_busy[s] = 1'b0;
            timer_count[s] = '0;
            timer_entry[s] = '0;
        end
        shadow_expire_level = 2'd1;
    endfunction

    // works out the result of one request and updates the shadow state
    function automatic t_outcome schedule_request(t_req req, logic [1:0] lvl,
                                                  logic [31:0] word,
                                                  logic [15:0] dly);
        t_outcome res;
        logic [31:0] dword;
        int unsigned drops;
        res = '0;
        dword = '0;
        drops = 0;
        case (req)
            REQ_SUBMIT: begin
                res.accepted = level_push(lvl, word);
            end
            REQ_TIMED: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (!timer_busy[s]) begin
                        timer_busy[s] = 1'b1;
                        timer_count[s] = dly;
                        timer_entry[s] = word;
                        res.accepted = 1'b1;
                        break;
                    end
                end
            end
            REQ_PROC: begin
                for (int l = 0; l < LEVELS; l++) begin
                    if (lvl_fill[l] != 0) begin
                        dword = lvl_store[l][lvl_rd[l]];
                        lvl_rd[l] = (lvl_rd[l] + 1) % SLOTS;
                        lvl_fill[l]--;
                        res.dispatch_valid = 1'b1;
                        break;
                    end
                end
                for (int s = 0; s < SLOTS; s++) begin
                    if (timer_busy[s] && timer_count[s] == 0) begin
                        if (!level_push(shadow_expire_level, timer_entry[s]) && drops < 31)
                            drops++;
                        timer_busy[s] = 1'b0;
                    end
                end
            end
            default: begin
                // tick: countdowns stop at zero
                for (int s = 0; s < SLOTS; s++)
                    if (timer_busy[s] && timer_count[s] != 0)
                        timer_count[s] = timer_count[s] - 1'b1;
            end
        endcase
        res.task_id = dword[7:0];
        res.event_code = dword[15:8];
        res.data_handle = dword[31:16];
        res.dropped = drops[4:0];
        return res;
    endfunction

    // ---- sender ----
    // valid stays high after a beat until the next gap, so a back-to-back
    // beat never drops and raises valid in the same time step
    task automatic send_request(t_req req, logic [1:0] lvl, logic [7:0] tid,
                                logic [7:0] ev, logic [15:0] dh, logic [15:0] dly);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type <= req;
        i_priority_req <= lvl;
        i_task_id <= tid;
        i_event_code <= ev;
        i_data_handle <= dh;
        i_delay <= dly;
        i_in_valid <= 1'b1;
        // accepted at the edge where valid is high and stall low
        do @(posedge i_clk); while (o_in_stall);
        pending_outcomes.push_back(schedule_request(req, lvl, {dh, ev, tid}, dly));
    endtask

    task automatic send_random(t_req req, logic [1:0] lvl, logic [15:0] dly);
        send_request(req, lvl, 8'($urandom), 8'($urandom), 16'($urandom), dly);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
    endtask

    task automatic write_expire_level(logic [1:0] lvl);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= lvl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_expire_level = lvl;
    endtask

    // ---- receiver: random stalls, plus a long hold-off on request ----
    initial begin
        int hold;
        i_out_stall = 1'b0;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                long_hold--;
                i_out_stall <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (o_out_valid && !i_out_stall && $urandom_range(0, 2) != 0)
                    hold = $urandom_range(0, 7);
            end
        end
    end

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_accepted, o_dispatch_valid, o_out_task_id, o_out_event_code,
                   o_out_data_handle, o_dropped_expired};
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                fail_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got.accepted !== want.accepted) begin
                    $display("%0t: accepted exp %0d got %0d", $time,
                             want.accepted, got.accepted);
                    fail_count++;
                end
                if (got.dispatch_valid !== want.dispatch_valid) begin
                    $display("%0t: dispatch_valid exp %0d got %0d", $time,
                             want.dispatch_valid, got.dispatch_valid);
                    fail_count++;
                end
                if (got.task_id !== want.task_id) begin
                    $display("%0t: task_id exp %h got %h", $time,
                             want.task_id, got.task_id);
                    fail_count++;
                end
                if (got.event_code !== want.event_code) begin
                    $display("%0t: event_code exp %h got %h", $time,
                             want.event_code, got.event_code);
                    fail_count++;
                end
                if (got.data_handle !== want.data_handle) begin
                    $display("%0t: data_handle exp %h got %h", $time,
                             want.data_handle, got.data_handle);
                    fail_count++;
                end
                if (got.dropped !== want.dropped) begin
                    $display("%0t: dropped_expired exp %0d got %0d", $time,
                             want.dropped, got.dropped);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || tb_done || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---- tests ----
    // extremes of every field, each request type, empty dispatch
    task automatic test_directed();
        send_request(REQ_PROC, 2'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_request(REQ_TICK, 2'd3, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(REQ_SUBMIT, 2'd0, 8'hFF, 8'h00, 16'hFFFF, 16'h0000);
        send_request(REQ_SUBMIT, 2'd3, 8'h00, 8'hFF, 16'h0000, 16'hFFFF);
        send_request(REQ_SUBMIT, 2'd1, 8'hA5, 8'h5A, 16'h1234, 16'h0000);
        // zero delay entry expires at the next process
        send_request(REQ_TIMED, 2'd0, 8'h11, 8'h22, 16'h3344, 16'h0000);
        send_request(REQ_TIMED, 2'd2, 8'h55, 8'h66, 16'h7788, 16'h0002);
        send_request(REQ_TIMED, 2'd1, 8'h99, 8'hAA, 16'hBBCC, 16'hFFFF);
        send_request(REQ_PROC, 2'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        // countdown already at zero stays there
        send_request(REQ_TICK, 2'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        repeat (5) send_request(REQ_PROC, 2'd0, 8'h00, 8'h00, 16'h0000, 16'h0000);
    endtask

    // fill the delay table past full, then fill the expiry level so expiries drop
    task automatic test_table_full_and_drops();
        for (int n = 0; n < SLOTS + 2; n++) send_random(REQ_TIMED, 2'($urandom), 16'd0);
        for (int n = 0; n < SLOTS + 2; n++) send_random(REQ_SUBMIT, 2'd3, 16'($urandom));
        write_expire_level(2'd3);
        send_random(REQ_PROC, 2'($urandom), 16'($urandom));
        write_expire_level(2'd0);
        for (int n = 0; n < SLOTS + 2; n++) send_random(REQ_PROC, 2'd0, 16'd0);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        long_hold = 300;
        for (int n = 0; n < 12; n++) send_random(REQ_SUBMIT, 2'($urandom), 16'($urandom));
        for (int n = 0; n < 12; n++) send_random(REQ_PROC, 2'($urandom), 16'($urandom));
    endtask

    // mostly short delays so entries actually expire; all types mixed
    task automatic test_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_random(REQ_SUBMIT, 2'($urandom), 16'($urandom));
            else if (pick < 50)
                send_random(REQ_TIMED, 2'($urandom),
                            ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 4)));
            else if (pick < 75)
                send_random(REQ_PROC, 2'($urandom), 16'($urandom));
            else
                send_random(REQ_TICK, 2'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        long_hold = 0;
        tb_done = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_priority_req = '0;
        i_task_id = '0;
        i_event_code = '0;
        i_data_handle = '0;
        i_delay = '0;
        shadow_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_table_full_and_drops();
        test_backpressure();
        write_expire_level(2'd1);
        test_random(250);
        write_expire_level(2'd2);
        test_random(200);
        write_expire_level(2'd3);
        test_random(200);

        wait_drained();
        tb_done = 1'b1;
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
